// ===== src/lob_pkg.sv =====
// Shared types and constants for the limit order book matcher.
package lob_pkg;

  localparam int BOOK_DEPTH = 64;
  localparam int IDX_W      = $clog2(BOOK_DEPTH);
  localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
  localparam int ADDR_W     = IDX_W + 1;

  // Result status codes.
  localparam logic [3:0] STAT_QUERY        = 4'd0;
  localparam logic [3:0] STAT_RESTED_TOP   = 4'd1;
  localparam logic [3:0] STAT_RESTED_BELOW = 4'd2;
  localparam logic [3:0] STAT_FULL         = 4'd3;
  localparam logic [3:0] STAT_TRADE        = 4'd4;
  localparam logic [3:0] STAT_NO_MATCH     = 4'd5;
  localparam logic [3:0] STAT_CANCEL_TOP   = 4'd6;
  localparam logic [3:0] STAT_CANCEL_BELOW = 4'd7;
  localparam logic [3:0] STAT_NOT_FOUND    = 4'd8;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_MATCH  = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_INS, S_MATCH, S_SHIFT, S_CANCEL, S_QUERY, S_RESP
  } state_e;

  // One resting order, price in the lowest bits.
  typedef struct packed {
    logic [31:0] oid;
    logic [15:0] user;
    logic [23:0] qty;
    logic [23:0] price;
  } entry_t;

  // Input item payload, last field (is_buy) in the lowest bits.
  typedef struct packed {
    logic [31:0] order_id;
    logic [15:0] user_id;
    logic [23:0] quantity;
    logic [23:0] price;
    logic        is_buy;
  } in_t;

  // Result item payload, last field (status) in the lowest bits.
  typedef struct packed {
    logic [31:0] top_quantity;
    logic [23:0] top_price;
    logic [23:0] remaining_quantity;
    logic [23:0] fill_price;
    logic [23:0] fill_quantity;
    logic [31:0] seller_order;
    logic [15:0] seller_user;
    logic [31:0] buyer_order;
    logic [15:0] buyer_user;
    logic        trade_valid;
    logic        cancel_side_buy;
    logic [3:0]  status;
  } res_t;

endpackage

// ===== src/lob_ram.sv =====
// Simple dual-port RAM with registered read.
module lob_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/lob_ctrl.sv =====
// Command sequencer that walks the book memory for add, match, cancel and query.
module lob_ctrl import lob_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmd_e              in_cmd_i,
  input  in_t               in_data_i,
  input  logic              out_busy_i,
  output logic              res_valid_o,
  output res_t              res_o,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output entry_t            wdata_o,
  output logic [ADDR_W-1:0] raddr_o,
  input  entry_t            rdata_i
);

  state_e state_q, state_d;
  in_t    in_q, in_d;
  res_t   res_q, res_d;
  logic   side_q, side_d;
  logic [CNT_W-1:0] bid_cnt_q, bid_cnt_d, ask_cnt_q, ask_cnt_d;
  logic [CNT_W-1:0] r_q, r_d, w_q, w_d;
  logic [IDX_W-1:0] ins_q, ins_d;
  logic [23:0] tp_q, tp_d;
  logic [31:0] sum_q, sum_d;
  logic        top_q, top_d, cside_q, cside_d;

  // Decision signals for the two control blocks; several are shared by both.
  logic [CNT_W-1:0] n, in_n, opp_n, in_nm1, rp1, rm1;
  logic        better, hit, last_r, r_end, cmatch, qcont, nq_zero;
  logic [23:0] fill, nq;
  logic [32:0] sum_ext;

  assign n      = side_q ? bid_cnt_q : ask_cnt_q;
  assign in_n   = in_data_i.is_buy ? bid_cnt_q : ask_cnt_q;
  assign opp_n  = in_data_i.is_buy ? ask_cnt_q : bid_cnt_q;
  assign in_nm1 = in_n - 1'b1;
  assign rp1    = r_q + 1'b1;
  assign rm1    = r_q - 1'b1;
  assign better = in_q.is_buy ? (in_q.price > rdata_i.price) : (in_q.price < rdata_i.price);
  assign hit    = (in_q.price == 24'd0) ||
                  (in_q.is_buy ? (in_q.price >= rdata_i.price) : (in_q.price <= rdata_i.price));
  assign fill   = (in_q.quantity < rdata_i.qty) ? in_q.quantity : rdata_i.qty;
  assign nq     = rdata_i.qty - fill;
  assign nq_zero = (nq == 24'd0);
  assign last_r = (r_q == n - 1'b1);
  assign r_end  = (r_q >= n);
  assign cmatch = (rdata_i.user == in_q.user_id) && (rdata_i.oid == in_q.order_id);
  assign qcont  = !r_end && ((r_q == '0) || (rdata_i.price == tp_q));
  assign sum_ext = {1'b0, sum_q} + {9'd0, rdata_i.qty};

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_cmd_i)
            CMD_ADD: begin
              if (in_n >= CNT_W'(BOOK_DEPTH)) state_d = S_RESP;
              else if (in_n == '0)            state_d = S_INS;
              else                            state_d = S_ADD;
            end
            CMD_MATCH:  state_d = (opp_n == '0) ? S_RESP : S_MATCH;
            CMD_CANCEL: state_d = S_CANCEL;
            CMD_QUERY:  state_d = (in_n == '0) ? S_RESP : S_QUERY;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_ADD:   if (!better || r_q == '0) state_d = S_INS;
      S_INS:   state_d = S_RESP;
      S_MATCH: begin
        if (!hit || !nq_zero || n == CNT_W'(1)) state_d = S_RESP;
        else                                    state_d = S_SHIFT;
      end
      S_SHIFT:  if (last_r) state_d = S_RESP;
      S_CANCEL: if (r_end && !side_q) state_d = S_RESP;
      S_QUERY:  if (!qcont) state_d = S_RESP;
      S_RESP:   if (!out_busy_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    in_d      = in_q;
    res_d     = res_q;
    side_d    = side_q;
    bid_cnt_d = bid_cnt_q;
    ask_cnt_d = ask_cnt_q;
    r_d       = r_q;
    w_d       = w_q;
    ins_d     = ins_q;
    tp_d      = tp_q;
    sum_d     = sum_q;
    top_d     = top_q;
    cside_d   = cside_q;
    we_o      = 1'b0;
    waddr_o   = {side_q, r_q[IDX_W-1:0]};
    wdata_o   = rdata_i;
    raddr_o   = {side_q, rp1[IDX_W-1:0]};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          res_d   = '0;
          r_d     = '0;
          w_d     = '0;
          ins_d   = '0;
          sum_d   = '0;
          top_d   = 1'b0;
          cside_d = 1'b0;
          unique case (in_cmd_i)
            CMD_ADD: begin
              side_d  = in_data_i.is_buy;
              r_d     = in_nm1;
              raddr_o = {in_data_i.is_buy, in_nm1[IDX_W-1:0]};
              if (in_n >= CNT_W'(BOOK_DEPTH)) res_d.status = STAT_FULL;
            end
            CMD_MATCH: begin
              side_d  = !in_data_i.is_buy;
              raddr_o = {!in_data_i.is_buy, {IDX_W{1'b0}}};
              if (opp_n == '0) begin
                res_d.status             = STAT_NO_MATCH;
                res_d.remaining_quantity = in_data_i.quantity;
              end
            end
            CMD_CANCEL: begin
              side_d  = 1'b1;
              raddr_o = {1'b1, {IDX_W{1'b0}}};
            end
            CMD_QUERY: begin
              side_d       = in_data_i.is_buy;
              raddr_o      = {in_data_i.is_buy, {IDX_W{1'b0}}};
              res_d.status = STAT_QUERY;
            end
            default: ;
          endcase
        end
      end
      // Walk down from the tail, shifting worse entries up by one.
      S_ADD: begin
        if (better) begin
          we_o    = 1'b1;
          waddr_o = {side_q, rp1[IDX_W-1:0]};
          if (r_q == '0) begin
            ins_d = '0;
          end else begin
            r_d     = rm1;
            raddr_o = {side_q, rm1[IDX_W-1:0]};
          end
        end else begin
          ins_d = rp1[IDX_W-1:0];
        end
      end
      // Place the new order in the opened slot.
      S_INS: begin
        we_o    = 1'b1;
        waddr_o = {side_q, ins_q};
        wdata_o = '{oid: in_q.order_id, user: in_q.user_id,
                    qty: in_q.quantity, price: in_q.price};
        if (side_q) bid_cnt_d = bid_cnt_q + 1'b1;
        else        ask_cnt_d = ask_cnt_q + 1'b1;
        res_d.status = (ins_q == '0) ? STAT_RESTED_TOP : STAT_RESTED_BELOW;
      end
      // One fill against the opposite top.
      S_MATCH: begin
        raddr_o = {side_q, rp1[IDX_W-1:0]};
        if (!hit) begin
          res_d.status             = STAT_NO_MATCH;
          res_d.remaining_quantity = in_q.quantity;
        end else begin
          res_d.status             = STAT_TRADE;
          res_d.trade_valid        = 1'b1;
          res_d.fill_quantity      = fill;
          res_d.fill_price         = rdata_i.price;
          res_d.remaining_quantity = in_q.quantity - fill;
          if (in_q.is_buy) begin
            res_d.buyer_user   = in_q.user_id;
            res_d.buyer_order  = in_q.order_id;
            res_d.seller_user  = rdata_i.user;
            res_d.seller_order = rdata_i.oid;
          end else begin
            res_d.buyer_user   = rdata_i.user;
            res_d.buyer_order  = rdata_i.oid;
            res_d.seller_user  = in_q.user_id;
            res_d.seller_order = in_q.order_id;
          end
          if (!nq_zero) begin
            we_o        = 1'b1;
            wdata_o.qty = nq;
          end else if (n == CNT_W'(1)) begin
            if (side_q) bid_cnt_d = '0;
            else        ask_cnt_d = '0;
          end else begin
            r_d = rp1;
          end
        end
      end
      // Close the gap left by an emptied top entry.
      S_SHIFT: begin
        we_o    = 1'b1;
        waddr_o = {side_q, rm1[IDX_W-1:0]};
        if (last_r) begin
          if (side_q) bid_cnt_d = n - 1'b1;
          else        ask_cnt_d = n - 1'b1;
        end else begin
          r_d = rp1;
        end
      end
      // Compact each side, dropping entries that carry the given IDs.
      S_CANCEL: begin
        if (r_end) begin
          if (side_q) bid_cnt_d = w_q;
          else        ask_cnt_d = w_q;
          if (side_q) begin
            cside_d = (n != w_q);
            side_d  = 1'b0;
            r_d     = '0;
            w_d     = '0;
            raddr_o = {1'b0, {IDX_W{1'b0}}};
          end else begin
            res_d.cancel_side_buy = cside_q;
            if (!cside_q && n == w_q) res_d.status = STAT_NOT_FOUND;
            else if (top_q)           res_d.status = STAT_CANCEL_TOP;
            else                      res_d.status = STAT_CANCEL_BELOW;
          end
        end else begin
          r_d = rp1;
          if (cmatch) begin
            if (r_q == '0) top_d = 1'b1;
          end else begin
            we_o    = (w_q != r_q);
            waddr_o = {side_q, w_q[IDX_W-1:0]};
            w_d     = w_q + 1'b1;
          end
        end
      end
      // Sum quantities at the top price.
      S_QUERY: begin
        if (qcont) begin
          if (r_q == '0) tp_d = rdata_i.price;
          sum_d = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
          r_d   = rp1;
        end else begin
          res_d.top_price    = tp_q;
          res_d.top_quantity = sum_q;
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bid_cnt_q <= '0;
      ask_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bid_cnt_q <= bid_cnt_d;
      ask_cnt_q <= ask_cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    res_q   <= res_d;
    side_q  <= side_d;
    r_q     <= r_d;
    w_q     <= w_d;
    ins_q   <= ins_d;
    tp_q    <= tp_d;
    sum_q   <= sum_d;
    top_q   <= top_d;
    cside_q <= cside_d;
  end

endmodule

// ===== src/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher: memory, sequencer and result register.
//
// Input items arrive on s_axis: tuser carries the command (add, match, cancel,
// query) and tdata the side, price, quantity, user and order identifiers.
// Every input item yields exactly one result item on m_axis.
// Both sides of the book live in one memory of 2 x 64 entries with a
// registered read; the sequencer streams through it one entry per cycle.
// Per item, a query reads the entries at the top price, a match moves the
// entries below an emptied top up by one, an add compares entries from the
// tail, and a cancel sweeps through both sides.
// The slowest command is the cancel, set by its sweep over both sides.
// A new item is taken once the previous one has left the sequencer, even if
// its result still waits in the output register.
// Reset clears both entry counts, so the book starts empty; memory contents
// need no clearing. A stalled receiver holds the result in place, and the
// sequencer waits with its next result until the output register frees.
module limit_order_book_matcher import lob_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: is_buy, price, quantity, user_id, order_id, zero pad
  input  logic [103:0] s_axis_tdata,
  // tuser: cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status, cancel_side_buy, trade_valid, buyer_user, buyer_order,
  // seller_user, seller_order, fill_quantity, fill_price, remaining_quantity,
  // top_price, top_quantity, zero pad
  output logic [231:0] m_axis_tdata
);

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t            wdata, rdata;
  logic              res_valid, out_busy;
  res_t              res;
  res_t              out_q;
  logic              out_valid_q;

  lob_ram #(
    .DATA_W($bits(entry_t)),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lob_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (cmd_e'(s_axis_tuser)),
    .in_data_i   (in_t'(s_axis_tdata[$bits(in_t)-1:0])),
    .out_busy_i  (out_busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  assign out_busy = out_valid_q && !m_axis_tready;

  // Output register for the result item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && !out_busy) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

endmodule

// ===== bench/limit_order_book_matcher_tb.sv =====
// Testbench for the limit order book matcher: directed table, random stream, book predictor.
`timescale 1ns / 1ps

module limit_order_book_matcher_tb;
  import lob_pkg::*;

  localparam int NUM_RANDOM = 610;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [231:0] m_axis_tdata;

  limit_order_book_matcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predicted book, one array per side, index 0 is the top.
  entry_t bid_book[BOOK_DEPTH];
  entry_t ask_book[BOOK_DEPTH];
  int     bid_n;
  int     ask_n;

  res_t   pending_results[$];
  int     fail_count;
  int     result_count;
  int     trade_count;
  int     full_count;
  bit     sender_done;

  // A directed row: the item plus an optional typed-in result.
  typedef struct {
    cmd_e        cmd;
    in_t         item;
    bit          fixed;
    res_t        res;
  } row_t;

  row_t directed_rows[$];

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Predict the result of one item and update the model book.
  function automatic res_t book_step(cmd_e cmd, in_t it);
    res_t   r;
    entry_t e;
    int     pos;
    int     w;
    int     nb;
    int     na;
    bit     tb;
    bit     ta;
    logic [23:0] tp;
    logic [23:0] rq;
    logic [23:0] f;
    longint sum;
    r = '0;
    case (cmd)
      CMD_ADD: begin
        e.price = it.price;
        e.qty   = it.quantity;
        e.user  = it.user_id;
        e.oid   = it.order_id;
        if (it.is_buy) begin
          if (bid_n >= BOOK_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            pos = 0;
            while (pos < bid_n && !(it.price > bid_book[pos].price)) pos++;
            for (int i = bid_n; i > pos; i--) bid_book[i] = bid_book[i-1];
            bid_book[pos] = e;
            bid_n++;
            r.status = (pos == 0) ? STAT_RESTED_TOP : STAT_RESTED_BELOW;
          end
        end else begin
          if (ask_n >= BOOK_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            pos = 0;
            while (pos < ask_n && !(it.price < ask_book[pos].price)) pos++;
            for (int i = ask_n; i > pos; i--) ask_book[i] = ask_book[i-1];
            ask_book[pos] = e;
            ask_n++;
            r.status = (pos == 0) ? STAT_RESTED_TOP : STAT_RESTED_BELOW;
          end
        end
      end
      CMD_MATCH: begin
        r.status = STAT_NO_MATCH;
        r.remaining_quantity = it.quantity;
        if (it.is_buy && ask_n > 0) begin
          tp = ask_book[0].price;
          if (it.price == 0 || it.price >= tp) begin
            rq = ask_book[0].qty;
            f = (it.quantity < rq) ? it.quantity : rq;
            r.status = STAT_TRADE;
            r.trade_valid = 1'b1;
            r.buyer_user = it.user_id;
            r.buyer_order = it.order_id;
            r.seller_user = ask_book[0].user;
            r.seller_order = ask_book[0].oid;
            r.fill_quantity = f;
            r.fill_price = tp;
            r.remaining_quantity = it.quantity - f;
            ask_book[0].qty = rq - f;
            if (ask_book[0].qty == 0) begin
              for (int i = 0; i + 1 < ask_n; i++) ask_book[i] = ask_book[i+1];
              ask_n--;
            end
          end
        end else if (!it.is_buy && bid_n > 0) begin
          tp = bid_book[0].price;
          if (it.price == 0 || it.price <= tp) begin
            rq = bid_book[0].qty;
            f = (it.quantity < rq) ? it.quantity : rq;
            r.status = STAT_TRADE;
            r.trade_valid = 1'b1;
            r.buyer_user = bid_book[0].user;
            r.buyer_order = bid_book[0].oid;
            r.seller_user = it.user_id;
            r.seller_order = it.order_id;
            r.fill_quantity = f;
            r.fill_price = tp;
            r.remaining_quantity = it.quantity - f;
            bid_book[0].qty = rq - f;
            if (bid_book[0].qty == 0) begin
              for (int i = 0; i + 1 < bid_n; i++) bid_book[i] = bid_book[i+1];
              bid_n--;
            end
          end
        end
      end
      CMD_CANCEL: begin
        tb = bid_n > 0 && bid_book[0].user == it.user_id && bid_book[0].oid == it.order_id;
        ta = ask_n > 0 && ask_book[0].user == it.user_id && ask_book[0].oid == it.order_id;
        w = 0;
        for (int i = 0; i < bid_n; i++) begin
          if (!(bid_book[i].user == it.user_id && bid_book[i].oid == it.order_id)) begin
            bid_book[w] = bid_book[i];
            w++;
          end
        end
        nb = bid_n - w;
        bid_n = w;
        w = 0;
        for (int i = 0; i < ask_n; i++) begin
          if (!(ask_book[i].user == it.user_id && ask_book[i].oid == it.order_id)) begin
            ask_book[w] = ask_book[i];
            w++;
          end
        end
        na = ask_n - w;
        ask_n = w;
        if (nb + na == 0) r.status = STAT_NOT_FOUND;
        else r.status = (tb || ta) ? STAT_CANCEL_TOP : STAT_CANCEL_BELOW;
        r.cancel_side_buy = nb > 0;
      end
      default: begin
        r.status = STAT_QUERY;
        sum = 0;
        if (it.is_buy && bid_n > 0) begin
          r.top_price = bid_book[0].price;
          for (int i = 0; i < bid_n && bid_book[i].price == r.top_price; i++) begin
            sum += bid_book[i].qty;
            if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
          end
        end else if (!it.is_buy && ask_n > 0) begin
          r.top_price = ask_book[0].price;
          for (int i = 0; i < ask_n && ask_book[i].price == r.top_price; i++) begin
            sum += ask_book[i].qty;
            if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
          end
        end
        r.top_quantity = sum[31:0];
      end
    endcase
    return r;
  endfunction

  // Draw a random gap length, mostly short and now and then long.
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Send one item and queue its prediction at acceptance.
  task automatic send_item(cmd_e cmd, in_t it, bit fixed, res_t fres);
    res_t pr;
    int   g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= 104'(it);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pr = book_step(cmd, it);
    if (pr.status == STAT_FULL) full_count++;
    if (fixed && pr != fres) begin
      $error("directed row expectation differs from prediction: %h vs %h", fres, pr);
      fail_count++;
    end
    pending_results.push_back(pr);
  endtask

  function automatic row_t mk_row(cmd_e c, bit b, int p, int q, int u, int o);
    row_t r;
    r.cmd = c;
    r.item.is_buy = b;
    r.item.price = 24'(p);
    r.item.quantity = 24'(q);
    r.item.user_id = 16'(u);
    r.item.order_id = 32'(o);
    r.fixed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  // Random item; mode 0 keeps prices in a narrow band so that books cross and tie, other modes draw wide prices.
  function automatic in_t rand_item(int mode);
    in_t it;
    it.is_buy = 1'($urandom_range(0, 1));
    it.price = (mode == 0) ? 24'($urandom_range(990, 1010)) : 24'($urandom());
    if ($urandom_range(0, 19) == 0) it.price = '0;
    it.quantity = ($urandom_range(0, 9) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 300));
    if ($urandom_range(0, 29) == 0) it.quantity = 24'hFFFFFF;
    it.user_id = (mode == 0) ? 16'($urandom_range(1, 6)) : 16'($urandom());
    it.order_id = (mode == 0) ? 32'($urandom_range(1, 12)) : $urandom();
    return it;
  endfunction

  // Stimulus.
  initial begin
    row_t rw;
    in_t  it;
    int   k;
    cmd_e c;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_ADD;
    bid_n = 0;
    ask_n = 0;
    fail_count = 0;
    result_count = 0;
    trade_count = 0;
    full_count = 0;
    sender_done = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty book behavior, typed-in results.
    rw = mk_row(CMD_QUERY, 1, 0, 0, 0, 0); rw.fixed = 1; rw.res.status = STAT_QUERY;
    directed_rows.push_back(rw);
    rw = mk_row(CMD_QUERY, 0, 0, 0, 0, 0); rw.fixed = 1; rw.res.status = STAT_QUERY;
    directed_rows.push_back(rw);
    rw = mk_row(CMD_MATCH, 1, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF);
    rw.fixed = 1; rw.res.status = STAT_NO_MATCH; rw.res.remaining_quantity = 24'hFFFFFF;
    directed_rows.push_back(rw);
    rw = mk_row(CMD_CANCEL, 0, 0, 0, 16'hFFFF, 32'hFFFFFFFF);
    rw.fixed = 1; rw.res.status = STAT_NOT_FOUND;
    directed_rows.push_back(rw);
    rw = mk_row(CMD_ADD, 1, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF);
    rw.fixed = 1; rw.res.status = STAT_RESTED_TOP;
    directed_rows.push_back(rw);
    // Ties, market and zero quantity rests, a large top-price sum.
    directed_rows.push_back(mk_row(CMD_ADD, 1, 24'hFFFFFF, 24'hFFFFFF, 1, 1));
    directed_rows.push_back(mk_row(CMD_ADD, 1, 24'hFFFFFF, 24'hFFFFFF, 2, 2));
    directed_rows.push_back(mk_row(CMD_ADD, 1, 24'hFFFFFF, 24'hFFFFFF, 3, 3));
    directed_rows.push_back(mk_row(CMD_QUERY, 1, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(CMD_ADD, 1, 0, 0, 4, 4));
    directed_rows.push_back(mk_row(CMD_ADD, 0, 0, 5, 5, 5));
    directed_rows.push_back(mk_row(CMD_ADD, 0, 1, 0, 6, 6));
    directed_rows.push_back(mk_row(CMD_QUERY, 0, 0, 0, 0, 0));
    // Zero quantity trade, market match, partial and full fills.
    directed_rows.push_back(mk_row(CMD_MATCH, 1, 24'hFFFFFF, 0, 7, 7));
    directed_rows.push_back(mk_row(CMD_MATCH, 1, 0, 3, 7, 8));
    directed_rows.push_back(mk_row(CMD_MATCH, 1, 0, 9, 7, 9));
    directed_rows.push_back(mk_row(CMD_MATCH, 0, 0, 24'hFFFFFF, 8, 1));
    directed_rows.push_back(mk_row(CMD_MATCH, 0, 24'hFFFFFF, 5, 8, 2));
    // Cancels below the top, on one side and on both sides.
    directed_rows.push_back(mk_row(CMD_ADD, 0, 50, 10, 3, 3));
    directed_rows.push_back(mk_row(CMD_CANCEL, 0, 0, 0, 2, 2));
    directed_rows.push_back(mk_row(CMD_CANCEL, 1, 0, 0, 3, 3));
    directed_rows.push_back(mk_row(CMD_CANCEL, 1, 0, 0, 4, 4));
    directed_rows.push_back(mk_row(CMD_QUERY, 1, 0, 0, 0, 0));
    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].item,
                directed_rows[i].fixed, directed_rows[i].res);

    // Fill the bid side to the brim, then overflow it.
    for (int i = 0; i < BOOK_DEPTH + 2; i++) begin
      it = rand_item(0);
      it.is_buy = 1'b1;
      send_item(CMD_ADD, it, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    // Hold off until every result is out.
    while (pending_results.size() != 0) @(posedge clk_i);

    // Random part, mostly narrow-band traffic, some wide noise.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      it = rand_item(($urandom_range(0, 9) == 0) ? 1 : 0);
      k = $urandom_range(0, 99);
      if (k < 40) c = CMD_ADD;
      else if (k < 70) c = CMD_MATCH;
      else if (k < 85) c = CMD_CANCEL;
      else c = CMD_QUERY;
      send_item(c, it, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: random stalls, compare with the oldest prediction.
  initial begin
    res_t got;
    res_t want;
    int   g;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
      result_count++;
      if (pending_results.size() == 0) begin
        $error("result arrived with no expectation waiting: %h", got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.trade_valid) trade_count++;
        if (got.status != want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status); fail_count++;
        end
        if (got.cancel_side_buy != want.cancel_side_buy) begin
          $error("cancel_side_buy expected %0d actual %0d",
                 want.cancel_side_buy, got.cancel_side_buy); fail_count++;
        end
        if (got.trade_valid != want.trade_valid) begin
          $error("trade_valid expected %0d actual %0d", want.trade_valid, got.trade_valid);
          fail_count++;
        end
        if (got.buyer_user != want.buyer_user) begin
          $error("buyer_user expected %0d actual %0d", want.buyer_user, got.buyer_user);
          fail_count++;
        end
        if (got.buyer_order != want.buyer_order) begin
          $error("buyer_order expected %0d actual %0d", want.buyer_order, got.buyer_order);
          fail_count++;
        end
        if (got.seller_user != want.seller_user) begin
          $error("seller_user expected %0d actual %0d", want.seller_user, got.seller_user);
          fail_count++;
        end
        if (got.seller_order != want.seller_order) begin
          $error("seller_order expected %0d actual %0d", want.seller_order, got.seller_order);
          fail_count++;
        end
        if (got.fill_quantity != want.fill_quantity) begin
          $error("fill_quantity expected %0d actual %0d",
                 want.fill_quantity, got.fill_quantity); fail_count++;
        end
        if (got.fill_price != want.fill_price) begin
          $error("fill_price expected %0d actual %0d", want.fill_price, got.fill_price);
          fail_count++;
        end
        if (got.remaining_quantity != want.remaining_quantity) begin
          $error("remaining_quantity expected %0d actual %0d",
                 want.remaining_quantity, got.remaining_quantity); fail_count++;
        end
        if (got.top_price != want.top_price) begin
          $error("top_price expected %0d actual %0d", want.top_price, got.top_price);
          fail_count++;
        end
        if (got.top_quantity != want.top_quantity) begin
          $error("top_quantity expected %0d actual %0d", want.top_quantity, got.top_quantity);
          fail_count++;
        end
      end
    end
  end

  // End of run: drain, settle, report.
  initial begin
    @(posedge rst_ni);
    wait (sender_done);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("Covered %0d results, %0d trades, %0d dropped adds on a full side.",
             result_count, trade_count, full_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("limit_order_book_matcher test passed");
    end else begin
      $display("limit_order_book_matcher test failed");
    end
    $finish;
  end

  // Watchdog, well above the slowest correct run.
  initial begin
    #20ms;
    $display("limit_order_book_matcher test failed");
    $finish;
  end

endmodule
